// ===== rtl/fsmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_pkg
// Shared types and codes for the first substring match finder.
// ----------------------------------------------------------------------------
package fsmf_pkg;

  localparam int UnitW  = 16;
  localparam int IndexW = 32;

  // request command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_TEXT   = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [UnitW-1:0] unit;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] match_index;
    logic              pattern_overflow;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic do_append;
    logic do_text;
    logic do_end;
    logic do_clear;
    logic cmp_run;
    logic cmp_finish;
  } fsmf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic text_cmp_due;
    logic cmp_done;
    logic out_free;
  } fsmf_status_t;

endpackage : fsmf_pkg
`default_nettype wire

// ===== rtl/fsmf_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_chan_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface fsmf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface : fsmf_chan_if
`default_nettype wire

// ===== rtl/fsmf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : fsmf_ram
`default_nettype wire

// ===== rtl/fsmf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_ctrl
// Controller: request acceptance and the window compare sequence.
// ----------------------------------------------------------------------------
module fsmf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_command,
  output logic                  req_ready,
  input  fsmf_pkg::fsmf_status_t status,
  output fsmf_pkg::fsmf_cmd_t   cmd
);
  import fsmf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CMP  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // an end request needs room in the result register
  assign req_ready = (state == ST_IDLE) && ((req_command != CMD_END) || status.out_free);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd            = '0;
    cmd.do_append  = accept && (req_command == CMD_APPEND);
    cmd.do_text    = accept && (req_command == CMD_TEXT);
    cmd.do_end     = accept && (req_command == CMD_END);
    cmd.do_clear   = accept && (req_command == CMD_CLEAR);
    cmd.cmp_run    = (state == ST_CMP);
    cmd.cmp_finish = (state == ST_CMP) && status.cmp_done;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.do_text && status.text_cmp_due) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.cmp_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : fsmf_ctrl
`default_nettype wire

// ===== rtl/fsmf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_dp
// Datapath: pattern and text window memories, counters, compare, result reg.
// ----------------------------------------------------------------------------
module fsmf_dp #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fsmf_pkg::UnitW-1:0]   req_unit,
  input  fsmf_pkg::fsmf_cmd_t          cmd,
  output fsmf_pkg::fsmf_status_t       status,
  input  logic                         res_ready,
  output logic                         res_valid,
  output fsmf_pkg::result_t            res
);
  import fsmf_pkg::*;

  localparam int AddrW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LenW  = $clog2(PATTERN_MAX + 1);
  localparam logic [LenW-1:0]  LenMax  = LenW'(PATTERN_MAX);
  localparam logic [LenW:0]    DepthX  = (LenW + 1)'(PATTERN_MAX);
  localparam logic [AddrW-1:0] AddrTop = AddrW'(PATTERN_MAX - 1);

  logic [LenW-1:0]   pat_len;
  logic              overflow;
  logic [AddrW-1:0]  wptr;       // next window slot to write
  logic [IndexW-1:0] text_pos;
  logic              match_seen;
  logic [IndexW-1:0] first_idx;

  // compare sequencer
  logic [LenW-1:0]   cmp_k;      // pattern index being issued
  logic [AddrW-1:0]  cmp_wa;     // window address being issued
  logic              cmp_pend;   // read data valid this cycle
  logic              cmp_miss;

  logic [UnitW-1:0]  pat_rdata;
  logic [UnitW-1:0]  win_rdata;
  logic              pat_we;
  logic              cmp_issue;
  logic [IndexW-1:0] pos_inc;
  logic [LenW:0]     wp1;
  logic [LenW:0]     len_x;
  logic [LenW:0]     start_x;
  logic [AddrW-1:0]  wptr_inc;
  logic [AddrW-1:0]  cmp_wa_inc;

  assign pat_we    = cmd.do_append && (pat_len < LenMax);
  assign cmp_issue = cmd.cmp_run && (cmp_k < pat_len);

  fsmf_ram #(.WIDTH(UnitW), .DEPTH(PATTERN_MAX)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_len[AddrW-1:0]),
    .wdata (req_unit),
    .raddr (cmp_k[AddrW-1:0]),
    .rdata (pat_rdata)
  );

  fsmf_ram #(.WIDTH(UnitW), .DEPTH(PATTERN_MAX)) u_win_ram (
    .clk   (clk),
    .we    (cmd.do_text),
    .waddr (wptr),
    .wdata (req_unit),
    .raddr (cmp_wa),
    .rdata (win_rdata)
  );

  assign pos_inc    = (text_pos == '1) ? text_pos : text_pos + 1'b1;
  assign wptr_inc   = (wptr == AddrTop) ? '0 : wptr + 1'b1;
  assign cmp_wa_inc = (cmp_wa == AddrTop) ? '0 : cmp_wa + 1'b1;

  // oldest window slot of the compared span, newest sits at wptr
  assign wp1     = (LenW + 1)'(wptr) + 1'b1;
  assign len_x   = (LenW + 1)'(pat_len);
  assign start_x = (wp1 >= len_x) ? (wp1 - len_x) : (wp1 + DepthX - len_x);

  always_comb begin
    status              = '0;
    status.text_cmp_due = !match_seen && !overflow && (pat_len != '0) &&
                          (pos_inc >= IndexW'(pat_len));
    status.cmp_done     = (cmp_k == pat_len) && !cmp_pend;
    status.out_free     = !res_valid || res_ready;
  end

  // pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len  <= '0;
      overflow <= 1'b0;
    end else if (cmd.do_clear) begin
      pat_len  <= '0;
      overflow <= 1'b0;
    end else if (cmd.do_append) begin
      if (pat_len < LenMax) begin
        pat_len <= pat_len + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      text_pos   <= '0;
      match_seen <= 1'b0;
      first_idx  <= '0;
    end else if (cmd.do_end) begin
      text_pos   <= '0;
      match_seen <= 1'b0;
      first_idx  <= '0;
    end else if (cmd.do_text) begin
      wptr     <= wptr_inc;
      text_pos <= pos_inc;
    end else if (cmd.cmp_finish && !cmp_miss) begin
      match_seen <= 1'b1;
      first_idx  <= text_pos - IndexW'(pat_len);
    end
  end

  // compare sequencer: issue one pair per cycle, check each pair in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_k    <= '0;
      cmp_wa   <= '0;
      cmp_pend <= 1'b0;
      cmp_miss <= 1'b0;
    end else if (cmd.do_text) begin
      cmp_k    <= '0;
      cmp_wa   <= start_x[AddrW-1:0];
      cmp_pend <= 1'b0;
      cmp_miss <= 1'b0;
    end else begin
      cmp_pend <= cmp_issue;
      if (cmp_issue) begin
        cmp_k  <= cmp_k + 1'b1;
        cmp_wa <= cmp_wa_inc;
      end
      if (cmp_pend && (pat_rdata != win_rdata)) begin
        cmp_miss <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.do_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_end) begin
      if (overflow) begin
        res.found            <= 1'b0;
        res.match_index      <= '0;
        res.pattern_overflow <= 1'b1;
      end else if (pat_len == '0) begin
        res.found            <= 1'b1;
        res.match_index      <= '0;
        res.pattern_overflow <= 1'b0;
      end else begin
        res.found            <= match_seen;
        res.match_index      <= match_seen ? first_idx : '0;
        res.pattern_overflow <= 1'b0;
      end
    end
  end

endmodule : fsmf_dp
`default_nettype wire

// ===== rtl/first_substring_match_finder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_substring_match_finder_unit
// Finds the first occurrence of a pattern of 16-bit units in a text stream.
// ----------------------------------------------------------------------------
// Usage:
//   request channel: command + unit. APPEND adds a pattern unit (beyond
//   PATTERN_MAX units it sets the overflow flag), TEXT shifts a unit into the
//   window, END closes the text and produces one result, CLEAR empties the
//   pattern and drops the overflow flag.
//   result channel: found, match_index, pattern_overflow, one per END.
// Sequencing:
//   APPEND, CLEAR and a TEXT request that needs no compare end at acceptance.
//   A TEXT request that must be checked (no match yet, no overflow, pattern
//   non-empty, enough text) holds off further requests while it runs:
//   acceptance, one unit pair read per cycle from the pattern memory and the
//   text window memory (set by their single read ports), the last read
//   landing, and the recording of the outcome.
//   END ends at acceptance; its result is valid the cycle after acceptance.
// Reset clears pattern length, overflow, text position and the result
// valid flag. A stalled result holds in its register while APPEND, TEXT and
// CLEAR requests keep flowing; only the next END waits for it to be taken.
// ----------------------------------------------------------------------------
module first_substring_match_finder_unit #(
  parameter int PATTERN_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  fsmf_chan_if.sink   request,
  fsmf_chan_if.source result
);
  import fsmf_pkg::*;

  fsmf_cmd_t    cmd;
  fsmf_status_t status;
  logic         req_ready;
  logic         res_valid;
  result_t      res;

  // sequencing: accept decisions and compare timing
  fsmf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (request.valid),
    .req_command (request.payload.command),
    .req_ready   (req_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // storage, counters, compare and result register
  fsmf_dp #(.PATTERN_MAX(PATTERN_MAX)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_unit  (request.payload.unit),
    .cmd       (cmd),
    .status    (status),
    .res_ready (result.ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign request.ready  = req_ready;
  assign result.valid   = res_valid;
  assign result.payload = res;

endmodule : first_substring_match_finder_unit
`default_nettype wire
